// ===== src/lom_pkg.sv =====
// shared types and constants of the limit order matcher
package lom_pkg;

    localparam int PRICE_LEVELS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 16;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic        side;
        logic [15:0] price;
        logic [23:0] quantity;
    } t_order;

    typedef struct packed {
        logic [23:0] filled_quantity;
        logic [23:0] rested_quantity;
        logic        rest_rejected;
        logic [15:0] best_bid;
        logic        best_bid_valid;
        logic [15:0] best_ask;
        logic        best_ask_valid;
    } t_result;

endpackage

// ===== src/lom_ram.sv =====
// generic single write port ram with registered read
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== src/lom_book.sv =====
// one side of the book: level records, resting queues and level valid bits
module lom_book
    import lom_pkg::*;
#(
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int REC_W        = 16,
    parameter int LW           = $clog2(PRICE_LEVELS),
    parameter int AW           = $clog2(PRICE_LEVELS * QUEUE_DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [LW-1:0]           i_lvl_rd_addr,
    output logic [REC_W-1:0]        o_lvl_rd_data,
    input  logic                    i_lvl_we,
    input  logic [LW-1:0]           i_lvl_wr_addr,
    input  logic [REC_W-1:0]        i_lvl_wr_data,
    input  logic [AW-1:0]           i_q_addr,
    output logic [23:0]             o_q_rd_data,
    input  logic                    i_q_we,
    input  logic [23:0]             i_q_wr_data,
    input  logic                    i_v_set,
    input  logic                    i_v_clr,
    input  logic [LW-1:0]           i_v_addr,
    output logic [PRICE_LEVELS-1:0] o_valid
);
    logic [PRICE_LEVELS-1:0] r_valid;

    // level valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_v_set) begin
            r_valid[i_v_addr] <= 1'b1;
        end else if (i_v_clr) begin
            r_valid[i_v_addr] <= 1'b0;
        end
    end

    assign o_valid = r_valid;

    // level records: price, queue head, queue count
    lom_ram #(.WIDTH(REC_W), .DEPTH(PRICE_LEVELS)) u_lvl_ram (
        .i_clk    (i_clk),
        .i_we     (i_lvl_we),
        .i_wr_addr(i_lvl_wr_addr),
        .i_wr_data(i_lvl_wr_data),
        .i_rd_addr(i_lvl_rd_addr),
        .o_rd_data(o_lvl_rd_data)
    );

    // resting quantities, one circular queue per level
    lom_ram #(.WIDTH(24), .DEPTH(PRICE_LEVELS * QUEUE_DEPTH)) u_q_ram (
        .i_clk    (i_clk),
        .i_we     (i_q_we),
        .i_wr_addr(i_q_addr),
        .i_wr_data(i_q_wr_data),
        .i_rd_addr(i_q_addr),
        .o_rd_data(o_q_rd_data)
    );
endmodule

// ===== src/limit_order_matcher.sv =====
// limit order matcher: sequencer over the bid and ask books
// An item is taken when start is high and busy is low; busy stays high until the
// result strobe, which is high for one cycle with the result and cannot be held off.
// One item keeps busy high through closing best bid and best ask scans over all
// price level slots. While quantity remains, each look at the opposite book adds a
// scan over its levels, including the last look that finds no level in range. Each
// resting order touched adds a queue read and compare, and each level visited a step
// to update or close it. A leftover adds a scan of its own side to find its own
// level or a free slot and rest. The level record ram, read one slot at a time with
// registered read, paces these scans.
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_order  i_order,
    output logic    o_result_strobe,
    output t_result o_result
);
    localparam int LW    = $clog2(PRICE_LEVELS);
    localparam int IW    = LW + 1;
    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int AW    = $clog2(PRICE_LEVELS * QUEUE_DEPTH);
    localparam int REC_W = 16 + QW + CW;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MSCAN_RD  = 4'd1;
    localparam logic [3:0] S_MSCAN_CMP = 4'd2;
    localparam logic [3:0] S_QRD       = 4'd3;
    localparam logic [3:0] S_QCMP      = 4'd4;
    localparam logic [3:0] S_LVL_DONE  = 4'd5;
    localparam logic [3:0] S_RSCAN_RD  = 4'd6;
    localparam logic [3:0] S_RSCAN_CMP = 4'd7;
    localparam logic [3:0] S_REST      = 4'd8;
    localparam logic [3:0] S_BSCAN_RD  = 4'd9;
    localparam logic [3:0] S_BSCAN_CMP = 4'd10;

    logic [3:0]    r_state, n_state;
    logic          r_side, n_side;
    logic [15:0]   r_limit, n_limit;
    logic [23:0]   r_qty, n_qty;
    logic [23:0]   r_rem, n_rem;
    logic [23:0]   r_rested, n_rested;
    logic          r_rej, n_rej;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_found, n_found;
    logic [LW-1:0] r_slot, n_slot;
    logic [15:0]   r_bprice, n_bprice;
    logic [QW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_free_ok, n_free_ok;
    logic [LW-1:0] r_free, n_free;
    logic          r_bs, n_bs;
    logic [15:0]   r_best_bid, n_best_bid;
    logic          r_bid_ok, n_bid_ok;
    logic          r_strobe, n_strobe;
    t_result       r_result, n_result;

    // book access signals
    logic                    acc_ask;
    logic [LW-1:0]           idx_lo;
    logic                    end_scan;
    logic                    cur_valid;
    logic [PRICE_LEVELS-1:0] bid_valid, ask_valid;
    logic [REC_W-1:0]        bid_lvl, ask_lvl, lvl_rd;
    logic [23:0]             bid_q, ask_q, q_rd;
    logic [15:0]             rec_price;
    logic [QW-1:0]           rec_head;
    logic [CW-1:0]           rec_cnt;
    logic                    lvl_we;
    logic [LW-1:0]           lvl_wr_addr;
    logic [REC_W-1:0]        lvl_wr_data;
    logic                    q_we;
    logic [23:0]             q_wr_data;
    logic                    v_set, v_clr;
    logic [LW-1:0]           v_addr;
    logic [LW-1:0]           sel_slot;
    logic [QW-1:0]           sel_off;
    logic [AW-1:0]           q_addr;
    logic [SW-1:0]           tail_sum;
    logic [QW-1:0]           tail_pos;
    logic [QW-1:0]           head_inc;
    logic                    want_high;
    logic                    better;

    // side being worked on: opposite book while matching, own book while resting
    always_comb begin
        unique case (r_state)
            S_MSCAN_RD, S_MSCAN_CMP, S_QRD, S_QCMP, S_LVL_DONE: acc_ask = (r_side == SIDE_BUY);
            S_RSCAN_RD, S_RSCAN_CMP, S_REST:                    acc_ask = (r_side == SIDE_SELL);
            default:                                            acc_ask = r_bs;
        endcase
    end

    assign idx_lo    = r_idx[LW-1:0];
    assign end_scan  = (r_idx == IW'(PRICE_LEVELS));
    assign cur_valid = acc_ask ? ask_valid[idx_lo] : bid_valid[idx_lo];
    assign lvl_rd    = acc_ask ? ask_lvl : bid_lvl;
    assign q_rd      = acc_ask ? ask_q : bid_q;
    assign rec_price = lvl_rd[REC_W-1 -: 16];
    assign rec_head  = lvl_rd[CW +: QW];
    assign rec_cnt   = lvl_rd[CW-1:0];

    // queue position arithmetic
    assign tail_sum = SW'(r_head) + SW'(r_cnt);
    assign tail_pos = (tail_sum >= SW'(QUEUE_DEPTH)) ? QW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : QW'(tail_sum);
    assign head_inc = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(r_head + 1'b1);

    // queue address: level slot times depth plus position
    always_comb begin
        if (r_state == S_REST) begin
            sel_slot = r_found ? r_slot : r_free;
            sel_off  = r_found ? tail_pos : '0;
        end else begin
            sel_slot = r_slot;
            sel_off  = r_head;
        end
    end
    assign q_addr = AW'(AW'(sel_slot) * AW'(QUEUE_DEPTH)) + AW'(sel_off);

    // compare unit for best level search
    always_comb begin
        if (r_state == S_BSCAN_CMP) begin
            want_high = (r_bs == 1'b0);
        end else begin
            want_high = (r_side == SIDE_SELL);
        end
        better = !r_found || (want_high ? (rec_price > r_bprice) : (rec_price < r_bprice));
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_limit    = r_limit;
        n_qty      = r_qty;
        n_rem      = r_rem;
        n_rested   = r_rested;
        n_rej      = r_rej;
        n_idx      = r_idx;
        n_found    = r_found;
        n_slot     = r_slot;
        n_bprice   = r_bprice;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_free_ok  = r_free_ok;
        n_free     = r_free;
        n_bs       = r_bs;
        n_best_bid = r_best_bid;
        n_bid_ok   = r_bid_ok;
        n_strobe   = 1'b0;
        n_result   = r_result;
        lvl_we      = 1'b0;
        lvl_wr_addr = r_slot;
        lvl_wr_data = {r_bprice, r_head, r_cnt};
        q_we        = 1'b0;
        q_wr_data   = r_rem;
        v_set       = 1'b0;
        v_clr       = 1'b0;
        v_addr      = r_slot;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_side   = i_order.side;
                    n_limit  = i_order.price;
                    n_qty    = i_order.quantity;
                    n_rem    = i_order.quantity;
                    n_rested = '0;
                    n_rej    = 1'b0;
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_bs     = 1'b0;
                    n_state  = (i_order.quantity == '0) ? S_BSCAN_RD : S_MSCAN_RD;
                end
            end

            // find best opposite level
            S_MSCAN_RD: begin
                if (end_scan) begin
                    n_idx = '0;
                    if (!r_found ||
                        (r_side == SIDE_BUY && r_bprice > r_limit) ||
                        (r_side == SIDE_SELL && r_bprice < r_limit)) begin
                        n_found   = 1'b0;
                        n_free_ok = 1'b0;
                        n_state   = S_RSCAN_RD;
                    end else begin
                        n_state = S_QRD;
                    end
                end else if (cur_valid) begin
                    n_state = S_MSCAN_CMP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_MSCAN_CMP: begin
                if (better) begin
                    n_found  = 1'b1;
                    n_slot   = idx_lo;
                    n_bprice = rec_price;
                    n_head   = rec_head;
                    n_cnt    = rec_cnt;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_MSCAN_RD;
            end

            // fill resting orders of the level in arrival order
            S_QRD: begin
                n_state = S_QCMP;
            end

            S_QCMP: begin
                if (q_rd <= r_rem) begin
                    n_rem  = r_rem - q_rd;
                    n_head = head_inc;
                    n_cnt  = r_cnt - 1'b1;
                    if (r_cnt == CW'(1) || q_rd == r_rem) begin
                        n_state = S_LVL_DONE;
                    end else begin
                        n_state = S_QRD;
                    end
                end else begin
                    q_we      = 1'b1;
                    q_wr_data = q_rd - r_rem;
                    n_rem     = '0;
                    n_state   = S_LVL_DONE;
                end
            end

            // retire or update the level, then look again or rest
            S_LVL_DONE: begin
                if (r_cnt == '0) begin
                    v_clr = 1'b1;
                end else begin
                    lvl_we = 1'b1;
                end
                n_idx     = '0;
                n_found   = 1'b0;
                n_free_ok = 1'b0;
                if (r_rem != '0) begin
                    n_state = S_MSCAN_RD;
                end else begin
                    n_state = S_BSCAN_RD;
                end
            end

            // find own level at the limit price and the lowest free slot
            S_RSCAN_RD: begin
                if (r_rem == '0) begin
                    n_state = S_BSCAN_RD;
                end else if (end_scan) begin
                    n_state = S_REST;
                end else if (cur_valid) begin
                    n_state = S_RSCAN_CMP;
                end else begin
                    if (!r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = idx_lo;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end

            S_RSCAN_CMP: begin
                if (!r_found && rec_price == r_limit) begin
                    n_found = 1'b1;
                    n_slot  = idx_lo;
                    n_head  = rec_head;
                    n_cnt   = rec_cnt;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_RSCAN_RD;
            end

            // append leftover or reject it
            S_REST: begin
                if (r_found) begin
                    if (SW'(r_cnt) < SW'(QUEUE_DEPTH)) begin
                        q_we        = 1'b1;
                        lvl_we      = 1'b1;
                        lvl_wr_data = {r_limit, r_head, CW'(r_cnt + 1'b1)};
                        n_rested    = r_rem;
                    end else begin
                        n_rej = 1'b1;
                    end
                end else if (r_free_ok) begin
                    q_we        = 1'b1;
                    lvl_we      = 1'b1;
                    lvl_wr_addr = r_free;
                    lvl_wr_data = {r_limit, QW'(0), CW'(1)};
                    v_set       = 1'b1;
                    v_addr      = r_free;
                    n_rested    = r_rem;
                end else begin
                    n_rej = 1'b1;
                end
                n_idx   = '0;
                n_found = 1'b0;
                n_bs    = 1'b0;
                n_state = S_BSCAN_RD;
            end

            // best bid scan, then best ask scan, then report
            S_BSCAN_RD: begin
                if (end_scan) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (r_bs == 1'b0) begin
                        n_best_bid = r_found ? r_bprice : '0;
                        n_bid_ok   = r_found;
                        n_bs       = 1'b1;
                    end else begin
                        n_result.filled_quantity = r_qty - r_rem;
                        n_result.rested_quantity = r_rested;
                        n_result.rest_rejected   = r_rej;
                        n_result.best_bid        = r_best_bid;
                        n_result.best_bid_valid  = r_bid_ok;
                        n_result.best_ask        = r_found ? r_bprice : '0;
                        n_result.best_ask_valid  = r_found;
                        n_strobe                 = 1'b1;
                        n_state                  = S_IDLE;
                    end
                end else if (cur_valid) begin
                    n_state = S_BSCAN_CMP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_BSCAN_CMP: begin
                if (better) begin
                    n_found  = 1'b1;
                    n_bprice = rec_price;
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_BSCAN_RD;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_side     <= n_side;
        r_limit    <= n_limit;
        r_qty      <= n_qty;
        r_rem      <= n_rem;
        r_rested   <= n_rested;
        r_rej      <= n_rej;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_slot     <= n_slot;
        r_bprice   <= n_bprice;
        r_head     <= n_head;
        r_cnt      <= n_cnt;
        r_free_ok  <= n_free_ok;
        r_free     <= n_free;
        r_bs       <= n_bs;
        r_best_bid <= n_best_bid;
        r_bid_ok   <= n_bid_ok;
        r_result   <= n_result;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // bid book
    lom_book #(
        .PRICE_LEVELS(PRICE_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH), .REC_W(REC_W),
        .LW(LW), .AW(AW)
    ) u_bid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lvl_rd_addr(idx_lo),
        .o_lvl_rd_data(bid_lvl),
        .i_lvl_we     (lvl_we && !acc_ask),
        .i_lvl_wr_addr(lvl_wr_addr),
        .i_lvl_wr_data(lvl_wr_data),
        .i_q_addr     (q_addr),
        .o_q_rd_data  (bid_q),
        .i_q_we       (q_we && !acc_ask),
        .i_q_wr_data  (q_wr_data),
        .i_v_set      (v_set && !acc_ask),
        .i_v_clr      (v_clr && !acc_ask),
        .i_v_addr     (v_addr),
        .o_valid      (bid_valid)
    );

    // ask book
    lom_book #(
        .PRICE_LEVELS(PRICE_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH), .REC_W(REC_W),
        .LW(LW), .AW(AW)
    ) u_ask (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_lvl_rd_addr(idx_lo),
        .o_lvl_rd_data(ask_lvl),
        .i_lvl_we     (lvl_we && acc_ask),
        .i_lvl_wr_addr(lvl_wr_addr),
        .i_lvl_wr_data(lvl_wr_data),
        .i_q_addr     (q_addr),
        .o_q_rd_data  (ask_q),
        .i_q_we       (q_we && acc_ask),
        .i_q_wr_data  (q_wr_data),
        .i_v_set      (v_set && acc_ask),
        .i_v_clr      (v_clr && acc_ask),
        .i_v_addr     (v_addr),
        .o_valid      (ask_valid)
    );
endmodule
